### sv/ostt_pkg.sv
package ostt_pkg;

    // default size of the timer table
    localparam int NUM_TIMERS_DEF = 16;

    // depths of the internal queues
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // identifier counter value after reset, and the id given when the table is full
    localparam logic [31:0] ID_FIRST = 32'd1;
    localparam logic [31:0] ID_NONE  = 32'd0;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_KILL  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_KILL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // incoming request
    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        now_ms;
        logic signed [15:0] delay_ms;
        logic [31:0]        kill_id;
    } req_item_t;

    // outgoing result
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] timer_id;
        logic        found;
        logic        last;
    } rsp_item_t;

    // classified command between front and back
    typedef enum logic [1:0] {
        OP_START,
        OP_TICK,
        OP_KILL
    } cmd_op_t;

    // arg holds the deadline for start, the time for tick, the id for kill
    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] arg;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

endpackage

### sv/one_shot_timer_table.sv
// one_shot_timer_table: a table of NUM_TIMERS one-shot timers
//
// requests come in through req with push/full: start (claims the lowest free
// slot, answers with a new id or 0 when full), tick (expires every due slot
// in slot order, one result each, then a done result), kill (frees the
// matching slot and answers found). results leave through rsp with empty/pop;
// last marks the final result of each request. the unused request code is
// taken and produces nothing.
//
// a request passes a two-entry command queue, then a sequencer reads one slot
// per cycle from the slot memory while the result queue has room: it takes the
// command, issues the first read, checks each slot in turn and, when no slot
// stops the scan, gives a closing result (start and kill stop at the first
// match). the slot memory has a single read port. while the result queue is
// full the sequencer holds, and the command queue keeps taking requests until
// it fills.
// reset frees all slots and sets the next id to 1; no clearing pass is run.
module one_shot_timer_table #(
    parameter int NUM_TIMERS = ostt_pkg::NUM_TIMERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ostt_pkg::req_item_t req,
    input  logic                push,
    output logic                full,
    output ostt_pkg::rsp_item_t rsp,
    output logic                empty,
    input  logic                pop
);

    localparam int RES_W = $bits(ostt_pkg::rsp_item_t);

    ostt_pkg::cmd_t      cmd;
    logic                cmd_empty;
    logic                cmd_pop;
    ostt_pkg::rsp_item_t res;
    logic                res_push;
    logic                res_full;
    logic [RES_W-1:0]    res_rdata;

    // request intake and classification
    ostt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    // slot sequencer
    ostt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // result queue
    ostt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ostt_pkg::RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (RES_W'(res)),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign rsp = ostt_pkg::rsp_item_t'(res_rdata);

endmodule

### sv/ostt_ram.sv
module ostt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/ostt_fifo.sv
module ostt_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/ostt_front.sv
module ostt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  ostt_pkg::req_item_t req,
    input  logic               push,
    output logic               full,
    output ostt_pkg::cmd_t     cmd,
    output logic               cmd_empty,
    input  logic               cmd_pop
);

    localparam int CMD_W = $bits(ostt_pkg::cmd_t);

    ostt_pkg::cmd_t   cmd_in;
    logic             keep;
    logic [31:0]      deadline;
    logic             q_full;
    logic [CMD_W-1:0] q_rdata;

    // deadline is now plus the sign-extended delay, wrapping at 32 bits
    assign deadline = req.now_ms + {{16{req.delay_ms[15]}}, req.delay_ms};

    // classify the request; the unused code is taken and dropped
    always_comb
    begin
        keep       = 1'b1;
        cmd_in.op  = ostt_pkg::OP_START;
        cmd_in.arg = deadline;
        unique case (req.req_type)
            ostt_pkg::REQ_START:
            begin
                cmd_in.op  = ostt_pkg::OP_START;
                cmd_in.arg = deadline;
            end
            ostt_pkg::REQ_TICK:
            begin
                cmd_in.op  = ostt_pkg::OP_TICK;
                cmd_in.arg = req.now_ms;
            end
            ostt_pkg::REQ_KILL:
            begin
                cmd_in.op  = ostt_pkg::OP_KILL;
                cmd_in.arg = req.kill_id;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full = q_full;
    assign cmd  = ostt_pkg::cmd_t'(q_rdata);

    // command queue toward the slot sequencer
    ostt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (ostt_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (CMD_W'(cmd_in)),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (cmd_empty)
    );

endmodule

### sv/ostt_back.sv
module ostt_back #(
    parameter int NUM_TIMERS = ostt_pkg::NUM_TIMERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ostt_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output ostt_pkg::rsp_item_t res,
    output logic                res_push,
    input  logic                res_full
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    ostt_pkg::scan_state_t state_reg, state_next;
    ostt_pkg::cmd_op_t     op_reg, op_next;
    logic [31:0]           arg_reg, arg_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [AW-1:0]         chk_idx_reg, chk_idx_next;
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [31:0]           next_id_reg, next_id_next;

    logic        go;
    logic        issue;
    logic        scan_end;
    logic        chk_act;
    logic        hit;
    logic        finish;
    logic [31:0] rd_id;
    logic [31:0] rd_dl;
    logic [31:0] id_inc;
    logic        ram_we;
    logic [63:0] ram_rdata;

    // scan: one slot read per cycle unless stalled, checked the cycle after
    assign go       = !res_full;
    assign issue    = (idx_reg < CW'(NUM_TIMERS));
    assign scan_end = !chk_valid_reg && !issue;
    assign chk_act  = active_reg[chk_idx_reg];
    assign rd_id    = ram_rdata[63:32];
    assign rd_dl    = ram_rdata[31:0];
    assign id_inc   = next_id_reg + 32'd1;

    // slot match for the command in flight
    always_comb
    begin
        unique case (op_reg)
            ostt_pkg::OP_START: hit = chk_valid_reg && !chk_act;
            ostt_pkg::OP_TICK:  hit = chk_valid_reg && chk_act && (arg_reg >= rd_dl);
            ostt_pkg::OP_KILL:  hit = chk_valid_reg && chk_act && (rd_id == arg_reg);
            default:            hit = 1'b0;
        endcase
    end

    assign finish = scan_end || (hit && (op_reg != ostt_pkg::OP_TICK));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ostt_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = ostt_pkg::ST_SCAN;
                end
            end
            ostt_pkg::ST_SCAN:
            begin
                if (go && finish)
                begin
                    state_next = ostt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ostt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res.result_kind = ostt_pkg::KIND_DONE;
        res.timer_id    = ostt_pkg::ID_NONE;
        res.found       = 1'b0;
        res.last        = 1'b1;
        ram_we          = 1'b0;
        op_next         = op_reg;
        arg_next        = arg_reg;
        idx_next        = idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        active_next     = active_reg;
        next_id_next    = next_id_reg;

        // result fields for the current check
        unique case (op_reg)
            ostt_pkg::OP_START:
            begin
                res.result_kind = ostt_pkg::KIND_START;
                res.timer_id    = hit ? next_id_reg : ostt_pkg::ID_NONE;
            end
            ostt_pkg::OP_KILL:
            begin
                res.result_kind = ostt_pkg::KIND_KILL;
                res.found       = hit;
            end
            ostt_pkg::OP_TICK:
            begin
                if (hit)
                begin
                    res.result_kind = ostt_pkg::KIND_EXPIRED;
                    res.timer_id    = rd_id;
                    res.last        = 1'b0;
                end
            end
            default:
            begin
                res.result_kind = ostt_pkg::KIND_DONE;
            end
        endcase

        unique case (state_reg)
            ostt_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop        = 1'b1;
                    op_next        = cmd.op;
                    arg_next       = cmd.arg;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                end
            end
            ostt_pkg::ST_SCAN:
            begin
                if (go)
                begin
                    res_push       = hit || scan_end;
                    idx_next       = issue ? idx_reg + CW'(1) : idx_reg;
                    chk_valid_next = issue && !finish;
                    chk_idx_next   = idx_reg[AW-1:0];
                    if (hit)
                    begin
                        if (op_reg == ostt_pkg::OP_START)
                        begin
                            ram_we                   = 1'b1;
                            active_next[chk_idx_reg] = 1'b1;
                            next_id_next = (id_inc == '0) ? ostt_pkg::ID_FIRST : id_inc;
                        end
                        else
                        begin
                            active_next[chk_idx_reg] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ostt_pkg::ST_IDLE;
            chk_valid_reg <= 1'b0;
            idx_reg       <= '0;
            active_reg    <= '0;
            next_id_reg   <= ostt_pkg::ID_FIRST;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            idx_reg       <= idx_next;
            active_reg    <= active_next;
            next_id_reg   <= next_id_next;
        end
    end

    // command payload and check index
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        arg_reg     <= arg_next;
        chk_idx_reg <= chk_idx_next;
    end

    // slot store: id in the upper half, deadline in the lower half
    ostt_ram #(
        .WIDTH (64),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chk_idx_reg),
        .wdata ({next_id_reg, arg_reg}),
        .re    ((state_reg == ostt_pkg::ST_SCAN) && go && issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // checks
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CW'(NUM_TIMERS))
        else $error("scan index past table end");

    a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ostt_pkg::ST_SCAN))
        else $error("slot check pending outside a scan");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != ostt_pkg::ID_NONE)
        else $error("identifier counter reached zero");

    a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (op_reg == ostt_pkg::OP_START) && hit)
            |=> (next_id_reg != $past(next_id_reg)))
        else $error("identifier counter did not advance after a start");

endmodule

### verif/one_shot_timer_table_tb.sv
`timescale 1ns / 1ps

module one_shot_timer_table_tb;

    localparam int          NUM_TIMERS  = ostt_pkg::NUM_TIMERS_DEF;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          RAND_ITEMS  = 390;
    localparam int          IDLE_PCT    = 26;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_WAIT  = 40;

    typedef struct {
        ostt_pkg::req_item_t item;
        bit                  typed;
        ostt_pkg::rsp_item_t want;
    } stim_row_t;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    ostt_pkg::req_item_t req   = '0;
    logic                push  = 1'b0;
    logic                full;
    ostt_pkg::rsp_item_t rsp;
    logic                empty;
    logic                pop   = 1'b0;

    // typed expectation that travels with the row being offered
    bit                  cur_typed = 1'b0;
    ostt_pkg::rsp_item_t cur_want  = '0;

    // flags shared between sender and receiver
    bit        calm      = 1'b0;
    bit        hold_go   = 1'b0;

    // shadow copy of the timer table
    bit          tt_active   [NUM_TIMERS];
    bit   [31:0] tt_id       [NUM_TIMERS];
    bit   [31:0] tt_deadline [NUM_TIMERS];
    logic [31:0] tt_next_id  = ostt_pkg::ID_FIRST;

    ostt_pkg::rsp_item_t step_out [$];
    ostt_pkg::rsp_item_t owed_rsp [$];
    stim_row_t           stim_rows [$];

    logic [31:0] cur_ms;
    int          mismatches = 0;
    int          n_req      = 0;
    int          n_rsp      = 0;
    int          n_expired  = 0;
    int          n_full     = 0;
    int          n_kill_hit = 0;

    one_shot_timer_table #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .push  (push),
        .full  (full),
        .rsp   (rsp),
        .empty (empty),
        .pop   (pop)
    );

    always #1 clk = ~clk;

    function automatic ostt_pkg::rsp_item_t mk_rsp(logic [1:0] kind, logic [31:0] id,
                                                   logic fnd, logic lst);
        ostt_pkg::rsp_item_t r;
        r.result_kind = kind;
        r.timer_id    = id;
        r.found       = fnd;
        r.last        = lst;
        return r;
    endfunction

    function automatic ostt_pkg::req_item_t mk_req(logic [1:0] kind, logic [31:0] now,
                                                   logic [15:0] dly, logic [31:0] kid);
        ostt_pkg::req_item_t r;
        r.req_type = kind;
        r.now_ms   = now;
        r.delay_ms = dly;
        r.kill_id  = kid;
        return r;
    endfunction

    // timer table behavior: updates the shadow table, leaves results in step_out
    task automatic apply_request(input ostt_pkg::req_item_t r);
        logic [31:0] dline;
        logic [31:0] new_id;
        bit          hit;
        step_out.delete();
        hit = 1'b0;
        unique case (r.req_type)
            ostt_pkg::REQ_START:
            begin
                new_id = ostt_pkg::ID_NONE;
                dline  = r.now_ms + {{16{r.delay_ms[15]}}, r.delay_ms};
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (!tt_active[i] && !hit)
                    begin
                        hit            = 1'b1;
                        new_id         = tt_next_id;
                        tt_id[i]       = tt_next_id;
                        tt_deadline[i] = dline;
                        tt_active[i]   = 1'b1;
                        tt_next_id     = tt_next_id + 32'd1;
                        if (tt_next_id == 32'd0)
                            tt_next_id = ostt_pkg::ID_FIRST;
                    end
                end
                if (!hit)
                    n_full++;
                step_out.push_back(mk_rsp(ostt_pkg::KIND_START, new_id, 1'b0, 1'b1));
            end
            ostt_pkg::REQ_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (tt_active[i] && r.now_ms >= tt_deadline[i])
                    begin
                        tt_active[i] = 1'b0;
                        step_out.push_back(mk_rsp(ostt_pkg::KIND_EXPIRED, tt_id[i],
                                                  1'b0, 1'b0));
                    end
                end
                step_out.push_back(mk_rsp(ostt_pkg::KIND_DONE, 32'd0, 1'b0, 1'b1));
            end
            ostt_pkg::REQ_KILL:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (tt_active[i] && tt_id[i] == r.kill_id && !hit)
                    begin
                        tt_active[i] = 1'b0;
                        hit          = 1'b1;
                    end
                end
                if (hit)
                    n_kill_hit++;
                step_out.push_back(mk_rsp(ostt_pkg::KIND_KILL, 32'd0, hit, 1'b1));
            end
            default:
            begin
            end
        endcase
    endtask

    // random request; time moves forward by up to 30 ms on each call
    function automatic ostt_pkg::req_item_t rand_request();
        ostt_pkg::req_item_t r;
        int                  pick;
        int                  sub;
        int                  slot;
        logic [15:0]         dly;
        logic [31:0]         kid;
        pick   = $urandom_range(0, 99);
        sub    = $urandom_range(0, 99);
        slot   = $urandom_range(0, NUM_TIMERS - 1);
        cur_ms = cur_ms + $urandom_range(0, 30);
        r      = mk_req(REQ_UNUSED, $urandom(), 16'($urandom()), $urandom());
        if (pick < 3)
        begin
            return r;
        end
        else if (pick < 43)
        begin
            if (sub < 75)
                dly = 16'($urandom_range(0, 200));
            else if (sub < 88)
                dly = 16'(-$urandom_range(1, 60));
            else
                dly = 16'($urandom());
            r = mk_req(ostt_pkg::REQ_START, cur_ms, dly, $urandom());
        end
        else if (pick < 72)
        begin
            r = mk_req(ostt_pkg::REQ_TICK, (sub < 6) ? $urandom() : cur_ms,
                       16'($urandom()), $urandom());
        end
        else
        begin
            if (sub < 60)
                kid = tt_id[slot];
            else if (sub < 75)
                kid = tt_next_id - $urandom_range(0, 3);
            else if (sub < 90)
                kid = $urandom();
            else
                kid = 32'd0;
            r = mk_req(ostt_pkg::REQ_KILL, $urandom(), 16'($urandom()), kid);
        end
        return r;
    endfunction

    task automatic add_row(input ostt_pkg::req_item_t it, input bit typed,
                           input ostt_pkg::rsp_item_t want);
        stim_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // offer one request and hold it until the transfer happens
    task automatic offer(input ostt_pkg::req_item_t it, input bit typed,
                         input ostt_pkg::rsp_item_t want);
        req       <= it;
        cur_typed <= typed;
        cur_want  <= want;
        push      <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // predict at every input transfer
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            apply_request(req);
            if (req.req_type != REQ_UNUSED)
                n_req++;
            if (cur_typed)
                owed_rsp.push_back(cur_want);
            else
                foreach (step_out[k])
                    owed_rsp.push_back(step_out[k]);
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        ostt_pkg::rsp_item_t w;
        if (rst_n && pop && !empty)
        begin
            n_rsp++;
            if (rsp.result_kind == ostt_pkg::KIND_EXPIRED)
                n_expired++;
            if (owed_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, actual kind=%0d id=%h found=%0d last=%0d",
                         $time, rsp.result_kind, rsp.timer_id, rsp.found, rsp.last);
            end
            else
            begin
                w = owed_rsp.pop_front();
                if (rsp.result_kind !== w.result_kind)
                begin
                    mismatches++;
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             w.result_kind, rsp.result_kind);
                end
                if (rsp.timer_id !== w.timer_id)
                begin
                    mismatches++;
                    $display("%0t: timer_id expected %h actual %h", $time,
                             w.timer_id, rsp.timer_id);
                end
                if (rsp.found !== w.found)
                begin
                    mismatches++;
                    $display("%0t: found expected %0d actual %0d", $time, w.found, rsp.found);
                end
                if (rsp.last !== w.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0d actual %0d", $time, w.last, rsp.last);
                end
            end
        end
    end

    // receiver: random pops, one long hold-off when the sender asks
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // sender: directed table, then random requests
    initial
    begin
        ostt_pkg::rsp_item_t none;
        ostt_pkg::req_item_t it;
        int                  sent;
        none = '0;
        cur_ms = $urandom();

        // tick and kill on an empty table
        add_row(mk_req(ostt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_DONE, 32'd0, 1'b0, 1'b1));
        add_row(mk_req(ostt_pkg::REQ_KILL, 32'd0, 16'd0, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_KILL, 32'd0, 1'b0, 1'b1));
        // starts at the extremes of time and delay
        add_row(mk_req(ostt_pkg::REQ_START, 32'd0, 16'd0, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_START, 32'd1, 1'b0, 1'b1));
        add_row(mk_req(ostt_pkg::REQ_START, 32'hFFFF_FFFF, 16'd1, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_START, 32'd2, 1'b0, 1'b1));
        add_row(mk_req(ostt_pkg::REQ_START, 32'd100, 16'h8000, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_START, 32'd3, 1'b0, 1'b1));
        add_row(mk_req(ostt_pkg::REQ_START, 32'd0, 16'h7FFF, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_START, 32'd4, 1'b0, 1'b1));
        // unused request code with every field set
        add_row(mk_req(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, none);
        // kill hit, then the same id again
        add_row(mk_req(ostt_pkg::REQ_KILL, 32'd0, 16'd0, 32'd2), 1'b1,
                mk_rsp(ostt_pkg::KIND_KILL, 32'd0, 1'b1, 1'b1));
        add_row(mk_req(ostt_pkg::REQ_KILL, 32'd0, 16'd0, 32'd2), 1'b1,
                mk_rsp(ostt_pkg::KIND_KILL, 32'd0, 1'b0, 1'b1));
        // tick at zero expires only the timer due at zero
        add_row(mk_req(ostt_pkg::REQ_TICK, 32'd0, 16'd0, 32'd0), 1'b0, none);
        add_row(mk_req(ostt_pkg::REQ_KILL, 32'd0, 16'd0, 32'hFFFF_FFFF), 1'b1,
                mk_rsp(ostt_pkg::KIND_KILL, 32'd0, 1'b0, 1'b1));
        // fill the table, one start too many, then expire everything
        for (int i = 0; i < 14; i++)
            add_row(mk_req(ostt_pkg::REQ_START, 32'd500, 16'($urandom()), 32'd0), 1'b0, none);
        add_row(mk_req(ostt_pkg::REQ_START, 32'd500, 16'd10, 32'd0), 1'b1,
                mk_rsp(ostt_pkg::KIND_START, ostt_pkg::ID_NONE, 1'b0, 1'b1));
        add_row(mk_req(ostt_pkg::REQ_TICK, 32'hFFFF_FFFF, 16'd0, 32'd0), 1'b0, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
            offer(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].want);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            if (sent == 60)
                hold_go = 1'b1;
            calm = (sent >= 200 && sent < 270);
            if (sent == 320)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (owed_rsp.size() != 0)
                    @(posedge clk);
            end
            it = rand_request();
            offer(it, 1'b0, none);
            if (it.req_type != REQ_UNUSED)
                sent++;
        end
        push <= 1'b0;
        calm = 1'b0;
        @(posedge clk);

        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d requests and %0d results: %0d expiries, %0d kills that hit,",
                 n_req, n_rsp, n_expired, n_kill_hit);
        $display("%0d starts on a full table, one long result stall and one drain pause",
                 n_full);
        if (mismatches == 0)
            $display("PASS one_shot_timer_table");
        else
            $display("FAIL one_shot_timer_table");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("FAIL one_shot_timer_table");
        $finish;
    end

endmodule
